>>> rtl/core/i2cme_pkg.sv
`default_nettype none

package i2cme_pkg;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Line step codes inside one command sequence.
  localparam logic [2:0] STEP_0 = 3'd0;
  localparam logic [2:0] STEP_1 = 3'd1;
  localparam logic [2:0] STEP_2 = 3'd2;
  localparam logic [2:0] STEP_3 = 3'd3;
  localparam logic [2:0] STEP_4 = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       read_last;
    logic       sda_sample;
    logic       scl_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] read_data;
  } out_item_t;

  typedef struct packed {
    logic [2:0] held_command;
    logic [2:0] step_index;
    logic [3:0] bit_index;
    logic [7:0] shift_value;
    logic       last_flag;
    logic       ack_flag;
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_hold;
  } engine_state_t;

endpackage

`default_nettype wire

>>> rtl/core/i2cme_step.sv
`default_nettype none

module i2cme_step (
  input  wire i2cme_pkg::engine_state_t cur,
  input  wire i2cme_pkg::in_item_t      item,
  output i2cme_pkg::engine_state_t      nxt,
  output logic                          done
);
  import i2cme_pkg::*;

  logic scl_up;

  // SCL counts as raised once it is released and the line reads high.
  assign scl_up = cur.scl_level & item.scl_sample;

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    case (cur.held_command)
      OP_TICK: begin
        if (item.operation >= OP_START && item.operation <= OP_READ) begin
          nxt.held_command = item.operation;
          nxt.step_index   = (item.operation == OP_READ) ? STEP_4 : STEP_0;
          nxt.bit_index    = 4'd0;
          if (item.operation == OP_WRITE) begin
            nxt.shift_value = item.data_byte;
          end else if (item.operation == OP_READ) begin
            nxt.shift_value = 8'd0;
            nxt.last_flag   = item.read_last;
          end
        end
      end
      OP_START: begin
        case (cur.step_index)
          STEP_0: begin nxt.scl_level = 1'b0; nxt.step_index = STEP_1; end
          STEP_1: begin nxt.sda_level = 1'b1; nxt.step_index = STEP_2; end
          STEP_2: begin
            nxt.scl_level = 1'b1;
            if (scl_up) nxt.step_index = STEP_3;
          end
          STEP_3: begin nxt.sda_level = 1'b0; nxt.step_index = STEP_4; end
          STEP_4: begin nxt.scl_level = 1'b0; done = 1'b1; end
          default: done = 1'b1;
        endcase
      end
      OP_STOP: begin
        case (cur.step_index)
          STEP_0: begin nxt.scl_level = 1'b0; nxt.step_index = STEP_1; end
          STEP_1: begin nxt.sda_level = 1'b0; nxt.step_index = STEP_2; end
          STEP_2: begin
            nxt.scl_level = 1'b1;
            if (scl_up) nxt.step_index = STEP_3;
          end
          STEP_3: begin nxt.sda_level = 1'b1; done = 1'b1; end
          default: done = 1'b1;
        endcase
      end
      OP_WRITE: begin
        if (cur.bit_index < BITS_PER_BYTE) begin
          case (cur.step_index)
            STEP_0: begin nxt.scl_level = 1'b0; nxt.step_index = STEP_1; end
            STEP_1: begin
              nxt.sda_level  = cur.shift_value[7];
              nxt.step_index = STEP_2;
            end
            STEP_2: begin
              nxt.scl_level = 1'b1;
              if (scl_up) begin
                nxt.shift_value = {cur.shift_value[6:0], 1'b0};
                nxt.bit_index   = cur.bit_index + 4'd1;
                nxt.step_index  = STEP_0;
              end
            end
            default: done = 1'b1;
          endcase
        end else begin
          case (cur.step_index)
            STEP_0: begin nxt.scl_level = 1'b0; nxt.step_index = STEP_1; end
            STEP_1: begin nxt.sda_level = 1'b1; nxt.step_index = STEP_2; end
            STEP_2: begin
              nxt.scl_level = 1'b1;
              if (scl_up) begin
                nxt.ack_flag   = ~item.sda_sample;
                nxt.step_index = STEP_3;
              end
            end
            STEP_3: begin nxt.scl_level = 1'b0; done = 1'b1; end
            default: done = 1'b1;
          endcase
        end
      end
      OP_READ: begin
        if (cur.bit_index < BITS_PER_BYTE) begin
          case (cur.step_index)
            STEP_4: begin nxt.sda_level = 1'b1; nxt.step_index = STEP_0; end
            STEP_0: begin nxt.scl_level = 1'b0; nxt.step_index = STEP_1; end
            STEP_1: begin
              nxt.scl_level = 1'b1;
              if (scl_up) begin
                nxt.shift_value = {cur.shift_value[6:0], item.sda_sample};
                nxt.bit_index   = cur.bit_index + 4'd1;
                nxt.step_index  = STEP_0;
              end
            end
            default: done = 1'b1;
          endcase
        end else begin
          case (cur.step_index)
            STEP_0: begin nxt.scl_level = 1'b0; nxt.step_index = STEP_1; end
            STEP_1: begin nxt.sda_level = cur.last_flag; nxt.step_index = STEP_2; end
            STEP_2: begin
              nxt.scl_level = 1'b1;
              if (scl_up) nxt.step_index = STEP_3;
            end
            STEP_3: begin nxt.scl_level = 1'b0; nxt.step_index = STEP_4; end
            STEP_4: begin
              nxt.sda_level = ~cur.last_flag;
              nxt.read_hold = cur.shift_value;
              done          = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
      end
      default: done = 1'b1;
    endcase

    // Finishing a command returns the engine to idle.
    if (done) begin
      nxt.held_command = OP_TICK;
      nxt.step_index   = STEP_0;
      nxt.bit_index    = 4'd0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/i2c_master_byte_engine_core.sv
`default_nettype none
// A result appears on the out_ channel in the cycle after its input transfer.
// Throughput: one transfer per cycle while out_ready is high; the engine state
// and the result register update together on every input transfer.
// Reset (rst_n low, synchronous): the engine goes idle with SCL and SDA released,
// all flags and the read byte cleared, and the result register empty.

module i2c_master_byte_engine_core (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire i2cme_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output i2cme_pkg::out_item_t  out_data
);
  import i2cme_pkg::*;

  engine_state_t state_r;
  engine_state_t state_nxt;
  out_item_t     out_r;
  out_item_t     out_nxt;
  logic          out_valid_r;
  logic          step_done;
  logic          in_fire;

  // A new item is taken whenever the result register is empty or is being
  // drained in the same cycle; input stalls only while a result waits unread.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // The whole line step for one item is one short combinational pass.
  i2cme_step u_step (
    .cur  (state_r),
    .item (in_data),
    .nxt  (state_nxt),
    .done (step_done)
  );

  always_comb begin
    out_nxt.scl_release = state_nxt.scl_level;
    out_nxt.sda_release = state_nxt.sda_level;
    out_nxt.busy_res    = (state_nxt.held_command != OP_TICK);
    out_nxt.done_res    = step_done;
    out_nxt.ack_ok      = state_nxt.ack_flag;
    out_nxt.read_data   = state_nxt.read_hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.held_command <= OP_TICK;
      state_r.step_index   <= STEP_0;
      state_r.bit_index    <= 4'd0;
      state_r.shift_value  <= 8'd0;
      state_r.last_flag    <= 1'b0;
      state_r.ack_flag     <= 1'b0;
      state_r.scl_level    <= 1'b1;
      state_r.sda_level    <= 1'b1;
      state_r.read_hold    <= 8'd0;
      out_valid_r          <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The result payload holds its value until the next input transfer.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Every input transfer leaves a result waiting on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("input transfer without a following result");

  // A finishing item leaves the engine idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_res) |-> !out_r.busy_res)
    else $error("done reported while still busy");

  // The bit counter never runs past one byte.
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bit_index <= BITS_PER_BYTE)
    else $error("bit counter out of range");

  // An idle engine keeps its sequence counters cleared.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.held_command == OP_TICK) |->
      (state_r.step_index == STEP_0 && state_r.bit_index == 4'd0))
    else $error("idle engine with stale step counters");

endmodule

`default_nettype wire
